/* design/fvws_pkg.sv */
`default_nettype none

package fvws_pkg;

   // block dimensions
   localparam int VOICES      = 4;
   localparam int WAVE_LEN    = 256;
   localparam int BUFFER_LEN  = 370;
   localparam int VOICE_W     = $clog2(VOICES);
   localparam int WAVE_AW     = $clog2(WAVE_LEN);
   localparam int STORE_DEPTH = VOICES * WAVE_LEN;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int SAMPLE_W    = 8;
   localparam int PHASE_W     = 24;
   localparam int FRAC_W      = 16;
   localparam int RATE_W      = 32;
   localparam int START_W     = 32;
   localparam int DUR_W       = 15;
   localparam int POS_W       = $clog2(BUFFER_LEN + 1);

   // datapath widths
   localparam int DIFF_W  = SAMPLE_W + 1;            // difference of two signed bytes
   localparam int ACC_W   = SAMPLE_W + FRAC_W + 2;   // blend accumulator
   localparam int SUM_W   = SAMPLE_W + 3;            // sum of four voices
   localparam int MAG_W   = SUM_W - 1;               // magnitude of that sum
   localparam int CNT_W   = $clog2(VOICES + 1);      // active voice count
   localparam int STEP_W  = $clog2(FRAC_W);          // serial step counter

   // channel widths
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SAMPLE_W-1:0] ZERO_LEVEL = 8'h80;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_START   = 2'd1,
      ACT_PRODUCE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STAT_SAMPLE    = 2'd0,
      STAT_SILENT    = 2'd1,
      STAT_EXHAUSTED = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RATE1    = 3'd0,
      REG_RATE2    = 3'd1,
      REG_RATE3    = 3'd2,
      REG_RATE4    = 3'd3,
      REG_START    = 3'd4,
      REG_DURATION = 3'd5
   } csr_reg_type;

endpackage

`default_nettype wire

/* design/fvws_ram.sv */
`default_nettype none

module fvws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/four_voice_wavetable_synth_top.sv */
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  tuser: action; tdata: voice, wave_index, wave_value
// rsp      out        rsp_tvalid/rsp_tready  tdata: sample_value; tuser: status; tlast
// csr      in         csr_we                 csr_index, csr_wdata (write only)
//
// load, start and the unused action code are handled in the idle state, which the block does not leave
// a sample is mixed in steps: each active
//   voice blends its two bytes by a bit-serial multiply over the 16 fraction bits, and
//   the mix is divided by the voice count in a 10-step restoring divider
// an exhausted duration, a silent buffer or a sample with no active voice goes from idle straight to the output state
// reset is synchronous; the wave store is not cleared and must be loaded before use
// a held result sits in the output register; loads and starts are still taken meanwhile,
//   a new sample waits at its last step until the register frees
`default_nettype none

module four_voice_wavetable_synth_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // slave side
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [fvws_pkg::REQ_DATA_W-1:0]     req_tdata,  // voice, wave_index, wave_value
   input  wire logic [fvws_pkg::REQ_USER_W-1:0]     req_tuser,  // action
   // master side
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [fvws_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // sample_value
   output logic      [fvws_pkg::RSP_USER_W-1:0]     rsp_tuser,  // status
   output logic                                     rsp_tlast,  // last_in_buffer
   // configuration writes
   input  wire logic                                csr_we,
   input  wire logic [fvws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [fvws_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // sequencer states
   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_VSEL  = 11'b000_0000_0010,
      ST_RDA   = 11'b000_0000_0100,
      ST_RDB   = 11'b000_0000_1000,
      ST_MINIT = 11'b000_0001_0000,
      ST_MUL   = 11'b000_0010_0000,
      ST_VACC  = 11'b000_0100_0000,
      ST_DINIT = 11'b000_1000_0000,
      ST_DIV   = 11'b001_0000_0000,
      ST_DONE  = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [fvws_pkg::RATE_W-1:0]  rate_ff [fvws_pkg::VOICES];
   logic [fvws_pkg::RATE_W-1:0]  rate_in [fvws_pkg::VOICES];
   logic [fvws_pkg::START_W-1:0] start_ff, start_in;
   logic [fvws_pkg::DUR_W-1:0]   dur_ff, dur_in;

   // synth state
   logic [fvws_pkg::PHASE_W-1:0] phase_ff [fvws_pkg::VOICES];
   logic [fvws_pkg::PHASE_W-1:0] phase_in [fvws_pkg::VOICES];
   logic [fvws_pkg::DUR_W-1:0]   buf_left_ff, buf_left_in;
   logic [fvws_pkg::POS_W-1:0]   pos_ff, pos_in;

   // per-sample working registers
   logic [fvws_pkg::VOICE_W-1:0]       v_ff, v_in;
   logic [fvws_pkg::WAVE_AW-1:0]       idx_ff, idx_in;
   logic [fvws_pkg::FRAC_W-1:0]        frac_ff, frac_in;       // multiplier bits, lsb first
   logic signed [fvws_pkg::SAMPLE_W-1:0] a_ff, a_in;
   logic signed [fvws_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [fvws_pkg::ACC_W-1:0]  mcand_ff, mcand_in;     // shifted difference
   logic [fvws_pkg::STEP_W-1:0]        step_ff, step_in;
   logic signed [fvws_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                               neg_ff, neg_in;
   logic [fvws_pkg::MAG_W-1:0]         quo_ff, quo_in;         // dividend in, quotient out
   logic [1:0]                         div_rem_ff, div_rem_in;

   // result staging and output register
   logic [fvws_pkg::SAMPLE_W-1:0] res_sample_ff, res_sample_in;
   fvws_pkg::status_type          res_status_ff, res_status_in;
   logic                          res_last_ff, res_last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fvws_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   fvws_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;

   // wave store port
   logic                           ram_we;
   logic [fvws_pkg::STORE_AW-1:0]  ram_waddr;
   logic [fvws_pkg::SAMPLE_W-1:0]  ram_wdata;
   logic [fvws_pkg::STORE_AW-1:0]  ram_raddr;
   logic [fvws_pkg::SAMPLE_W-1:0]  ram_rdata;

   // helpers
   logic [fvws_pkg::VOICES-1:0]        active;
   logic [fvws_pkg::CNT_W-1:0]         count;
   logic                               req_xfer;
   logic                               rsp_free;
   logic                               at_boundary;
   logic signed [fvws_pkg::SAMPLE_W-1:0] b_val;
   logic signed [fvws_pkg::DIFF_W-1:0] diff;
   logic signed [fvws_pkg::ACC_W-1:0]  acc_adj;
   logic signed [fvws_pkg::DIFF_W-1:0] blend;
   logic [fvws_pkg::MAG_W:0]           sum_mag;
   logic [2:0]                         div_trial;
   logic                               div_ge;
   logic [2:0]                         div_sub;
   logic [fvws_pkg::SAMPLE_W-1:0]      quo_low;
   logic [fvws_pkg::SAMPLE_W-1:0]      mix;

   fvws_ram #(
      .WIDTH (fvws_pkg::SAMPLE_W),
      .DEPTH (fvws_pkg::STORE_DEPTH)
   ) u_wave (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign at_boundary = (pos_ff == '0);

   // a voice with a nonzero rate takes part in the mix
   always_comb begin
      count = '0;
      for (int i = 0; i < fvws_pkg::VOICES; i++) begin
         active[i] = |rate_ff[i];
         count     = count + fvws_pkg::CNT_W'(active[i]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      rate_in       = rate_ff;
      start_in      = start_ff;
      dur_in        = dur_ff;
      phase_in      = phase_ff;
      buf_left_in   = buf_left_ff;
      pos_in        = pos_ff;
      v_in          = v_ff;
      idx_in        = idx_ff;
      frac_in       = frac_ff;
      a_in          = a_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      step_in       = step_ff;
      sum_in        = sum_ff;
      neg_in        = neg_ff;
      quo_in        = quo_ff;
      div_rem_in    = div_rem_ff;
      res_sample_in = res_sample_ff;
      res_status_in = res_status_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sample_in = rsp_sample_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      ram_we    = 1'b0;
      ram_waddr = {req_tdata[1:0], req_tdata[9:2]};
      ram_wdata = req_tdata[17:10];
      ram_raddr = {v_ff, idx_ff};

      // signed byte of the neighbor and the blend of the finished accumulator
      b_val     = signed'(ram_rdata ^ fvws_pkg::ZERO_LEVEL);
      diff      = fvws_pkg::DIFF_W'(b_val) - fvws_pkg::DIFF_W'(a_ff);
      // round toward zero: bias negative values before the arithmetic shift
      acc_adj   = acc_ff + (acc_ff[fvws_pkg::ACC_W-1]
                  ? fvws_pkg::ACC_W'({fvws_pkg::FRAC_W{1'b1}}) : '0);
      blend     = acc_adj[fvws_pkg::FRAC_W +: fvws_pkg::DIFF_W];
      sum_mag   = sum_ff[fvws_pkg::SUM_W-1] ? fvws_pkg::SUM_W'(-sum_ff)
                                            : fvws_pkg::SUM_W'(sum_ff);
      div_trial = {div_rem_ff, quo_ff[fvws_pkg::MAG_W-1]};
      div_ge    = (div_trial >= count);
      div_sub   = div_trial - count;
      quo_low   = quo_ff[fvws_pkg::SAMPLE_W-1:0];
      mix       = neg_ff ? (~quo_low + 1'b1) : quo_low;

      // configuration writes: the user must issue them only while idle; the block does not enforce it
      if (csr_we) begin
         case (fvws_pkg::csr_reg_type'(csr_index))
            fvws_pkg::REG_RATE1:    rate_in[0] = csr_wdata;
            fvws_pkg::REG_RATE2:    rate_in[1] = csr_wdata;
            fvws_pkg::REG_RATE3:    rate_in[2] = csr_wdata;
            fvws_pkg::REG_RATE4:    rate_in[3] = csr_wdata;
            fvws_pkg::REG_START:    start_in   = csr_wdata;
            fvws_pkg::REG_DURATION: dur_in     = csr_wdata[fvws_pkg::DUR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (fvws_pkg::action_type'(req_tuser))
                  fvws_pkg::ACT_LOAD: begin
                     ram_we = 1'b1;
                  end
                  fvws_pkg::ACT_START: begin
                     for (int i = 0; i < fvws_pkg::VOICES; i++) begin
                        phase_in[i] = {start_ff[8*i +: fvws_pkg::WAVE_AW],
                                       {fvws_pkg::FRAC_W{1'b0}}};
                     end
                     buf_left_in = dur_ff;
                     pos_in      = '0;
                  end
                  fvws_pkg::ACT_PRODUCE: begin
                     res_sample_in = fvws_pkg::ZERO_LEVEL;
                     res_status_in = fvws_pkg::STAT_SAMPLE;
                     res_last_in   = 1'b0;
                     state_in      = ST_OUT;
                     if (at_boundary && buf_left_ff == '0) begin
                        // duration used up: nothing moves
                        res_status_in = fvws_pkg::STAT_EXHAUSTED;
                     end else if (at_boundary && count == '0) begin
                        // whole buffer passes silently
                        buf_left_in   = buf_left_ff - 1'b1;
                        res_status_in = fvws_pkg::STAT_SILENT;
                        res_last_in   = 1'b1;
                     end else begin
                        if (at_boundary) begin
                           buf_left_in = buf_left_ff - 1'b1;
                        end
                        if (pos_ff == fvws_pkg::POS_W'(fvws_pkg::BUFFER_LEN - 1)) begin
                           pos_in      = '0;
                           res_last_in = 1'b1;
                        end else begin
                           pos_in = pos_ff + 1'b1;
                        end
                        if (count != '0) begin
                           v_in     = '0;
                           sum_in   = '0;
                           state_in = ST_VSEL;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_VSEL: begin
            if (active[v_ff]) begin
               state_in = ST_RDA;
            end else if (v_ff == fvws_pkg::VOICE_W'(fvws_pkg::VOICES - 1)) begin
               state_in = ST_DINIT;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end

         ST_RDA: begin
            // first byte at the integer part of the phase
            idx_in    = phase_ff[v_ff][fvws_pkg::PHASE_W-1 -: fvws_pkg::WAVE_AW];
            frac_in   = phase_ff[v_ff][fvws_pkg::FRAC_W-1:0];
            ram_raddr = {v_ff, phase_ff[v_ff][fvws_pkg::PHASE_W-1 -: fvws_pkg::WAVE_AW]};
            state_in  = ST_RDB;
         end

         ST_RDB: begin
            // neighbor byte, index wraps within the voice's wave
            ram_raddr = {v_ff, idx_ff + 1'b1};
            a_in      = signed'(ram_rdata ^ fvws_pkg::ZERO_LEVEL);
            state_in  = ST_MINIT;
         end

         ST_MINIT: begin
            // a*(1-f) + b*f = a + (b-a)*f, scaled by 2^16
            acc_in   = fvws_pkg::ACC_W'({fvws_pkg::ACC_W'(a_ff), {fvws_pkg::FRAC_W{1'b0}}});
            mcand_in = fvws_pkg::ACC_W'(diff);
            step_in  = '0;
            phase_in[v_ff] = phase_ff[v_ff] + rate_ff[v_ff][fvws_pkg::PHASE_W-1:0];
            state_in = ST_MUL;
         end

         ST_MUL: begin
            if (frac_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = mcand_ff <<< 1;
            frac_in  = frac_ff >> 1;
            step_in  = step_ff + 1'b1;
            if (step_ff == fvws_pkg::STEP_W'(fvws_pkg::FRAC_W - 1)) begin
               state_in = ST_VACC;
            end
         end

         ST_VACC: begin
            sum_in = sum_ff + fvws_pkg::SUM_W'(blend);
            if (v_ff == fvws_pkg::VOICE_W'(fvws_pkg::VOICES - 1)) begin
               state_in = ST_DINIT;
            end else begin
               v_in     = v_ff + 1'b1;
               state_in = ST_VSEL;
            end
         end

         ST_DINIT: begin
            // divide the magnitude, restore the sign afterwards (truncation toward zero)
            neg_in     = sum_ff[fvws_pkg::SUM_W-1];
            quo_in     = sum_mag[fvws_pkg::MAG_W-1:0];
            div_rem_in = '0;
            step_in    = '0;
            state_in   = ST_DIV;
         end

         ST_DIV: begin
            quo_in     = {quo_ff[fvws_pkg::MAG_W-2:0], div_ge};
            div_rem_in = div_ge ? div_sub[1:0] : div_trial[1:0];
            step_in    = step_ff + 1'b1;
            if (step_ff == fvws_pkg::STEP_W'(fvws_pkg::MAG_W - 1)) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            res_sample_in = mix + fvws_pkg::ZERO_LEVEL;
            state_in      = ST_OUT;
         end

         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_sample_ff;
               rsp_status_in = res_status_ff;
               rsp_last_in   = res_last_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= '0;
         dur_ff       <= '0;
         buf_left_ff  <= '0;
         pos_ff       <= '0;
         for (int i = 0; i < fvws_pkg::VOICES; i++) begin
            rate_ff[i]  <= '0;
            phase_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         dur_ff       <= dur_in;
         buf_left_ff  <= buf_left_in;
         pos_ff       <= pos_in;
         rate_ff      <= rate_in;
         phase_ff     <= phase_in;
      end
      // datapath and payload registers
      v_ff          <= v_in;
      idx_ff        <= idx_in;
      frac_ff       <= frac_in;
      a_ff          <= a_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      step_ff       <= step_in;
      sum_ff        <= sum_in;
      neg_ff        <= neg_in;
      quo_ff        <= quo_in;
      div_rem_ff    <= div_rem_in;
      res_sample_ff <= res_sample_in;
      res_status_ff <= res_status_in;
      res_last_ff   <= res_last_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* design/fvws_checker.sv */
`default_nettype none

module fvws_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [fvws_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic [fvws_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input wire logic                                rsp_tlast
);

   // exhausted duration gives a zero-level sample that ends no buffer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == fvws_pkg::STAT_EXHAUSTED
      |-> rsp_tdata == fvws_pkg::ZERO_LEVEL && !rsp_tlast)
      else $error("exhausted result carries wrong sample or last");

   // a silent buffer is consumed whole
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == fvws_pkg::STAT_SILENT
      |-> rsp_tdata == fvws_pkg::ZERO_LEVEL && rsp_tlast)
      else $error("silent buffer result carries wrong sample or last");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready
      |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind four_voice_wavetable_synth_top fvws_checker u_fvws_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // percent of cycles in which either side holds off
   localparam int IDLE_PCT = 29;
   // room for the slowest sample, one with all four voices active, plus margin
   localparam int DRAIN_CYCLES = 160;
   // action code that the block takes and then ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   // random part stops after about this many requests that do something
   localparam int RANDOM_REQUESTS = 400;

   // one request as it travels on the slave side
   typedef struct packed {
      logic [1:0] action;
      logic [1:0] voice;
      logic [7:0] wave_index;
      logic [7:0] wave_value;
   } synth_request_type;

   // one mixed output sample with its status and buffer marker
   typedef struct packed {
      logic [fvws_pkg::SAMPLE_W-1:0] sample_value;
      fvws_pkg::status_type          status;
      logic                          last_in_buffer;
   } mix_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [fvws_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // voice, wave_index, wave_value
   logic [fvws_pkg::REQ_USER_W-1:0] req_tuser = '0;  // action

   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [fvws_pkg::RSP_DATA_W-1:0] rsp_tdata;  // sample_value
   logic [fvws_pkg::RSP_USER_W-1:0] rsp_tuser;  // status
   logic                            rsp_tlast;  // last_in_buffer

   logic                            csr_we = 1'b0;
   logic [fvws_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fvws_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   four_voice_wavetable_synth_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // requests waiting for the driver, and samples the mixer model says are due
   synth_request_type queued_requests[$];
   mix_result_type    predicted_samples[$];
   synth_request_type next_request;

   // register copies kept in step with every csr write
   logic [fvws_pkg::RATE_W-1:0]  voice_rate [fvws_pkg::VOICES];
   logic [fvws_pkg::START_W-1:0] start_bytes;
   logic [fvws_pkg::DUR_W-1:0]   duration_setting;

   // synthesizer state as the model sees it
   logic [fvws_pkg::SAMPLE_W-1:0] wave_mem [fvws_pkg::STORE_DEPTH];
   logic [fvws_pkg::PHASE_W-1:0]  voice_phase [fvws_pkg::VOICES];
   logic [fvws_pkg::DUR_W-1:0]    buffers_left;
   int                            buffer_pos;

   int mismatches = 0;
   bit steady = 1'b0;   // no hold-off on either side while set
   bit req_xfer = 1'b0; // a request transfer happened at the last rising edge

   initial begin
      forever #6 clock = ~clock;
   end

   // linear blend of two neighboring wave bytes of one voice, truncated toward zero
   function automatic int voice_level(logic [1:0] v, logic [fvws_pkg::PHASE_W-1:0] ph);
      logic [7:0] i;
      logic [7:0] j;
      int a;
      int b;
      int f;
      i = ph[fvws_pkg::PHASE_W-1:fvws_pkg::FRAC_W];
      j = i + 8'd1;
      a = int'(wave_mem[{v, i}]) - 128;
      b = int'(wave_mem[{v, j}]) - 128;
      f = int'(ph[fvws_pkg::FRAC_W-1:0]);
      if (f == 0)
         return a;
      return (a * (65536 - f) + b * f) / 65536;
   endfunction

   // update the model with one accepted request, queueing the sample it causes
   function automatic void mix_request(synth_request_type r);
      int active;
      int level_sum;
      mix_result_type res;
      active = 0;
      level_sum = 0;
      case (r.action)
         fvws_pkg::ACT_LOAD: begin
            wave_mem[{r.voice, r.wave_index}] = r.wave_value;
         end
         fvws_pkg::ACT_START: begin
            for (int v = 0; v < fvws_pkg::VOICES; v++)
               voice_phase[v] = {start_bytes[8*v +: 8], 16'h0000};
            buffers_left = duration_setting;
            buffer_pos = 0;
         end
         fvws_pkg::ACT_PRODUCE: begin
            for (int v = 0; v < fvws_pkg::VOICES; v++)
               if (voice_rate[v] != 0)
                  active++;
            res.sample_value = fvws_pkg::ZERO_LEVEL;
            res.status = fvws_pkg::STAT_SAMPLE;
            res.last_in_buffer = 1'b0;
            if (buffer_pos == 0) begin
               // nothing left to play: state stays put
               if (buffers_left == 0) begin
                  res.status = fvws_pkg::STAT_EXHAUSTED;
                  predicted_samples.push_back(res);
                  return;
               end
               buffers_left = buffers_left - 1'b1;
               // whole buffer skipped when every voice is off at its start
               if (active == 0) begin
                  res.status = fvws_pkg::STAT_SILENT;
                  res.last_in_buffer = 1'b1;
                  predicted_samples.push_back(res);
                  return;
               end
            end
            if (active != 0) begin
               for (int v = 0; v < fvws_pkg::VOICES; v++)
                  if (voice_rate[v] != 0)
                     level_sum += voice_level(v[1:0], voice_phase[v]);
               res.sample_value = 8'(level_sum / active + 128);
            end
            // rate bits above the phase width drop out
            for (int v = 0; v < fvws_pkg::VOICES; v++)
               voice_phase[v] = voice_phase[v] + voice_rate[v][fvws_pkg::PHASE_W-1:0];
            buffer_pos++;
            if (buffer_pos >= fvws_pkg::BUFFER_LEN) begin
               buffer_pos = 0;
               res.last_in_buffer = 1'b1;
            end
            predicted_samples.push_back(res);
         end
         default: begin
            // unused code: taken and ignored
         end
      endcase
   endfunction

   function automatic void check_sample();
      mix_result_type exp_res;
      if (predicted_samples.size() == 0) begin
         $error("unexpected rsp transfer: sample_value %0h status %0d last %0b",
                rsp_tdata, rsp_tuser, rsp_tlast);
         mismatches++;
         return;
      end
      exp_res = predicted_samples.pop_front();
      if (rsp_tdata !== exp_res.sample_value) begin
         $error("sample_value expected %0h actual %0h", exp_res.sample_value, rsp_tdata);
         mismatches++;
      end
      if (rsp_tuser !== exp_res.status) begin
         $error("status expected %0d actual %0d", exp_res.status, rsp_tuser);
         mismatches++;
      end
      if (rsp_tlast !== exp_res.last_in_buffer) begin
         $error("last_in_buffer expected %0b actual %0b", exp_res.last_in_buffer, rsp_tlast);
         mismatches++;
      end
   endfunction

   // monitor: results are checked before the request of the same edge is modeled
   always @(posedge clock) begin
      if (reset) begin
         req_xfer = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_sample();
         req_xfer = req_tvalid && req_tready;
         if (req_xfer)
            mix_request('{action: req_tuser, voice: req_tdata[1:0],
                          wave_index: req_tdata[9:2], wave_value: req_tdata[17:10]});
      end
   end

   // driver: moves on from an item only after its transfer, otherwise holds it
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         if (!req_tvalid || req_xfer) begin
            if (queued_requests.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               next_request = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_request.action;
               req_tdata  <= {6'b0, next_request.wave_value, next_request.wave_index,
                              next_request.voice};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic queue_request(logic [1:0] action, logic [1:0] voice = 2'd0,
                                logic [7:0] wave_index = 8'd0, logic [7:0] wave_value = 8'd0);
      queued_requests.push_back('{action, voice, wave_index, wave_value});
   endtask

   // register write, mirrored into the model copy
   task automatic program_reg(fvws_pkg::csr_reg_type idx, logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         fvws_pkg::REG_START:    start_bytes = val;
         fvws_pkg::REG_DURATION: duration_setting = val[fvws_pkg::DUR_W-1:0];
         default:                voice_rate[int'(idx)] = val;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_rates(logic [31:0] r1, logic [31:0] r2,
                                logic [31:0] r3, logic [31:0] r4);
      program_reg(fvws_pkg::REG_RATE1, r1);
      program_reg(fvws_pkg::REG_RATE2, r2);
      program_reg(fvws_pkg::REG_RATE3, r3);
      program_reg(fvws_pkg::REG_RATE4, r4);
   endtask

   // wait until every request went out and every sample came back, then let it settle
   task automatic drain();
      while (queued_requests.size() != 0 || req_tvalid || predicted_samples.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(3))
         0: return 32'd0;
         1: return $urandom_range(32'h0003_0000, 1);
         2: return $urandom;
         default: begin
            case ($urandom_range(2))
               0: return 32'hFFFF_FFFF;
               1: return 32'h00FF_FFFF;
               default: return 32'h0100_0000;
            endcase
         end
      endcase
   endfunction

   initial begin : stimulus
      int p;
      int n;
      int roll;
      int random_items;
      bit long_run;
      logic [31:0] pick;

      random_items = 0;
      for (int v = 0; v < fvws_pkg::VOICES; v++) begin
         voice_rate[v] = '0;
         voice_phase[v] = '0;
      end
      start_bytes = '0;
      duration_setting = '0;
      buffers_left = '0;
      buffer_pos = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole wave store so no sample ever reads an unwritten byte
      for (int a = 0; a < fvws_pkg::STORE_DEPTH; a++)
         queue_request(fvws_pkg::ACT_LOAD, a[9:8], a[7:0], 8'($urandom));
      // duration is zero after reset, so produce reports exhausted
      queue_request(fvws_pkg::ACT_PRODUCE);
      queue_request(ACT_UNUSED, 2'd3, 8'hFF, 8'hFF);
      queue_request(fvws_pkg::ACT_PRODUCE);
      drain();

      // extreme rates: whole steps, all ones, half steps, the smallest step
      program_rates(32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_0001);
      program_reg(fvws_pkg::REG_START, 32'hFFFF_FFFF);
      program_reg(fvws_pkg::REG_DURATION, 32'd2);
      queue_request(fvws_pkg::ACT_LOAD, 2'd0, 8'h00, 8'h00);
      queue_request(fvws_pkg::ACT_LOAD, 2'd3, 8'hFF, 8'hFF);
      queue_request(fvws_pkg::ACT_START);
      repeat (6) queue_request(fvws_pkg::ACT_PRODUCE);
      drain();

      // every voice turned off part way through a buffer, then a zero duration
      program_rates(32'd0, 32'd0, 32'd0, 32'd0);
      program_reg(fvws_pkg::REG_DURATION, 32'd0);
      program_reg(fvws_pkg::REG_START, 32'd0);
      repeat (2) queue_request(fvws_pkg::ACT_PRODUCE);
      queue_request(fvws_pkg::ACT_START);
      queue_request(fvws_pkg::ACT_PRODUCE);
      drain();

      // silent buffers with the longest duration
      program_reg(fvws_pkg::REG_DURATION, 32'h7FFF);
      queue_request(fvws_pkg::ACT_START);
      repeat (2) queue_request(fvws_pkg::ACT_PRODUCE);
      drain();

      // rate whose low bits are zero keeps the voice active yet frozen
      program_reg(fvws_pkg::REG_RATE4, 32'h0100_0000);
      program_reg(fvws_pkg::REG_RATE1, 32'h00FF_FFFF);
      repeat (3) queue_request(fvws_pkg::ACT_PRODUCE);
      drain();

      // random phases: mostly start followed by a run of samples, with some noise
      p = 0;
      while (random_items < RANDOM_REQUESTS) begin
         long_run = (p % 5 == 2);
         steady = (p == 2);
         program_rates(pick_rate(), pick_rate(), pick_rate(), pick_rate());
         case ($urandom_range(3))
            0: pick = 32'd0;
            1: pick = 32'hFFFF_FFFF;
            default: pick = $urandom;
         endcase
         program_reg(fvws_pkg::REG_START, pick);
         if (long_run)
            pick = $urandom_range(2, 1);
         else begin
            case ($urandom_range(9))
               0: pick = 32'd0;
               1: pick = 32'h7FFF;
               2: pick = $urandom_range(32'h7FFF);
               default: pick = $urandom_range(3, 1);
            endcase
         end
         program_reg(fvws_pkg::REG_DURATION, pick);

         // leaving out the start keeps the buffer position of the last phase
         if (long_run || $urandom_range(99) < 75) begin
            queue_request(fvws_pkg::ACT_START);
            random_items++;
         end
         n = long_run ? $urandom_range(420, 380) : $urandom_range(90, 15);
         for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               queue_request(fvws_pkg::ACT_LOAD, 2'($urandom), 8'($urandom), 8'($urandom));
               random_items++;
            end else if (roll < 11) begin
               queue_request(fvws_pkg::ACT_START);
               random_items++;
            end else if (roll < 14) begin
               queue_request(ACT_UNUSED, 2'($urandom), 8'($urandom), 8'($urandom));
            end
            queue_request(fvws_pkg::ACT_PRODUCE);
            random_items++;
         end
         drain();
         p++;
      end

      if (mismatches == 0 && predicted_samples.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
design/fvws_pkg.sv
design/fvws_ram.sv
design/four_voice_wavetable_synth_top.sv
design/fvws_checker.sv
tb/testbench.sv
